// ===== src/record_batch_frame_checker_defines.svh =====
// Assertion helpers for the checker's top-level RTL file.
`ifndef RECORD_BATCH_FRAME_CHECKER_DEFINES_SVH
`define RECORD_BATCH_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RBFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record batch frame checker: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RBFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record batch frame checker: assertion failed");

`endif

// ===== src/rbfc_pkg.sv =====
`timescale 1ns / 1ps
package rbfc_pkg;

   localparam int unsigned RBFC_RECORD_HEADER_SIZE = 16;
   localparam logic [63:0] BATCH_HEADER_BYTES = 64'd32;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_HEADER_SHORT  = 3'd1,
      ST_MAGIC_BAD     = 3'd2,
      ST_SIZE_SMALL    = 3'd3,
      ST_PAYLOAD_SHORT = 3'd4,
      ST_CRC_BAD       = 3'd5,
      ST_COUNT_ZERO    = 3'd6,
      ST_COUNT_BIG     = 3'd7
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] first_offset;
      logic [63:0] rec_total;
      logic [63:0] batch_size;
      logic [31:0] payload_crc;
   } rbfc_result_type;

   typedef struct packed {
      logic            valid;
      rbfc_result_type result;
   } rbfc_push_type;

   // Reflected CRC-32, one byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic status_type final_status(input logic crc_bad, input logic count_zero,
                                               input logic too_big);
      if (crc_bad) begin
         return ST_CRC_BAD;
      end else if (count_zero) begin
         return ST_COUNT_ZERO;
      end else if (too_big) begin
         return ST_COUNT_BIG;
      end
      return ST_OK;
   endfunction

endpackage

// ===== src/rbfc_parser.sv =====
`timescale 1ns / 1ps
module rbfc_parser #(
   parameter int unsigned RECORD_HEADER_SIZE = rbfc_pkg::RBFC_RECORD_HEADER_SIZE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             data_byte,
   input  logic                   buffer_end,
   input  logic [31:0]            magic_word,
   output rbfc_pkg::rbfc_push_type push
);

   localparam int unsigned RW = $clog2(RECORD_HEADER_SIZE + 1);
   localparam int unsigned PW = 64 + RW;
   localparam int unsigned MW = 16 + RW;

   logic [63:0]   pos_ff, pos_in;
   logic [31:0]   magic_ff, magic_in;
   logic [63:0]   offset_ff, offset_in;
   logic [63:0]   count_ff, count_in;
   logic [63:0]   size_ff, size_in;
   logic [31:0]   hcrc_ff, hcrc_in;
   logic [31:0]   crc_ff, crc_in;
   logic          finished_ff, finished_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic          too_big_ff, too_big_in;

   logic          in_header;
   logic [4:0]    idx;
   logic [4:0]    rel;
   logic [1:0]    chunk_sel;
   logic [15:0]   chunk;
   logic [MW-1:0] partial;
   logic [31:0]   crc_next;
   logic [63:0]   pos_inc;
   logic          emit;
   logic          with_header;
   logic          clear;
   rbfc_pkg::status_type status;

   assign in_header = (pos_ff[63:5] == 59'd0);
   assign idx       = pos_ff[4:0];
   assign crc_next  = rbfc_pkg::crc_byte(crc_ff, data_byte);
   assign pos_inc   = pos_ff + 64'd1;
   assign clear     = fire && buffer_end;

   // Count times record size, one 16-bit slice of the count per header byte 20..23.
   assign chunk_sel = 2'(idx - 5'd20);
   assign chunk     = count_ff[{chunk_sel, 4'b0} +: 16];
   assign partial   = MW'(chunk) * MW'(RECORD_HEADER_SIZE);

   always_comb begin
      pos_in      = pos_ff;
      magic_in    = magic_ff;
      offset_in   = offset_ff;
      count_in    = count_ff;
      size_in     = size_ff;
      hcrc_in     = hcrc_ff;
      crc_in      = crc_ff;
      finished_in = finished_ff;
      prod_in     = prod_ff;
      too_big_in  = too_big_ff;
      emit        = 1'b0;
      with_header = 1'b1;
      status      = rbfc_pkg::ST_OK;
      rel         = 5'd0;

      if (fire && !finished_ff) begin
         if (in_header) begin
            if (idx < 5'd4) begin
               magic_in[{idx[1:0], 3'b0} +: 8] = data_byte;
            end else if (idx < 5'd12) begin
               rel = idx - 5'd4;
               offset_in[{rel[2:0], 3'b0} +: 8] = data_byte;
            end else if (idx < 5'd20) begin
               rel = idx - 5'd12;
               count_in[{rel[2:0], 3'b0} +: 8] = data_byte;
            end else if (idx < 5'd28) begin
               rel = idx - 5'd20;
               size_in[{rel[2:0], 3'b0} +: 8] = data_byte;
            end else begin
               rel = idx - 5'd28;
               hcrc_in[{rel[1:0], 3'b0} +: 8] = data_byte;
            end

            if (idx >= 5'd20 && idx < 5'd24) begin
               prod_in = prod_ff + (PW'(partial) << {chunk_sel, 4'b0});
            end
            // Size is complete once byte 27 is in.
            if (idx == 5'd28) begin
               too_big_in = prod_ff > PW'(size_ff - rbfc_pkg::BATCH_HEADER_BYTES);
            end

            if (idx == 5'd31) begin
               if (magic_in != magic_word) begin
                  emit   = 1'b1;
                  status = rbfc_pkg::ST_MAGIC_BAD;
               end else if (size_in < rbfc_pkg::BATCH_HEADER_BYTES) begin
                  emit   = 1'b1;
                  status = rbfc_pkg::ST_SIZE_SMALL;
               end else if (size_in == rbfc_pkg::BATCH_HEADER_BYTES) begin
                  // Empty payload: CRC of nothing is zero, capacity is zero.
                  emit   = 1'b1;
                  status = rbfc_pkg::final_status(hcrc_in != 32'd0, count_in == 64'd0,
                                                  1'b1);
               end else if (buffer_end) begin
                  emit   = 1'b1;
                  status = rbfc_pkg::ST_PAYLOAD_SHORT;
               end
            end else if (buffer_end) begin
               emit        = 1'b1;
               with_header = 1'b0;
               status      = rbfc_pkg::ST_HEADER_SHORT;
            end
         end else begin
            crc_in = crc_next;
            if (pos_inc == size_ff) begin
               emit   = 1'b1;
               status = rbfc_pkg::final_status(~crc_next != hcrc_ff, count_ff == 64'd0,
                                               too_big_ff);
            end else if (buffer_end) begin
               emit   = 1'b1;
               status = rbfc_pkg::ST_PAYLOAD_SHORT;
            end
         end

         if (emit && !buffer_end) begin
            finished_in = 1'b1;
         end else if (!buffer_end) begin
            pos_in = pos_inc;
         end
      end
   end

   always_comb begin
      push.valid               = emit;
      push.result.status       = status;
      push.result.first_offset = with_header ? offset_in : 64'd0;
      push.result.rec_total    = with_header ? count_in : 64'd0;
      push.result.batch_size   = with_header ? size_in : 64'd0;
      push.result.payload_crc  = with_header ? hcrc_in : 32'd0;
   end

   // Buffer end returns to the idle state, also after a finished batch.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pos_ff      <= 64'd0;
         magic_ff    <= 32'd0;
         offset_ff   <= 64'd0;
         count_ff    <= 64'd0;
         size_ff     <= 64'd0;
         hcrc_ff     <= 32'd0;
         crc_ff      <= rbfc_pkg::CRC_INIT;
         finished_ff <= 1'b0;
         prod_ff     <= '0;
         too_big_ff  <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         magic_ff    <= magic_in;
         offset_ff   <= offset_in;
         count_ff    <= count_in;
         size_ff     <= size_in;
         hcrc_ff     <= hcrc_in;
         crc_ff      <= crc_in;
         finished_ff <= finished_in;
         prod_ff     <= prod_in;
         too_big_ff  <= too_big_in;
      end
   end

endmodule

// ===== src/rbfc_out_buffer.sv =====
`timescale 1ns / 1ps
module rbfc_out_buffer (
   input  logic                     clock,
   input  logic                     reset,
   input  rbfc_pkg::rbfc_push_type  push,
   output logic                     hold,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rbfc_pkg::rbfc_result_type rsp_result
);

   logic                      out_valid_ff, out_valid_in;
   rbfc_pkg::rbfc_result_type out_ff, out_in;
   logic                      skid_valid_ff, skid_valid_in;
   rbfc_pkg::rbfc_result_type skid_ff, skid_in;
   logic                      open;

   // Output register is free when empty or its beat leaves this cycle.
   assign open = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (open) begin
         out_valid_in  = skid_valid_ff || push.valid;
         out_in        = skid_valid_ff ? skid_ff : push.result;
         skid_valid_in = 1'b0;
      end else if (push.valid) begin
         skid_valid_in = 1'b1;
         skid_in       = push.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign hold       = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

// ===== src/record_batch_frame_checker.sv =====
`timescale 1ns / 1ps
`include "record_batch_frame_checker_defines.svh"
// Record batch frame checker: takes one buffer byte per beat and delivers one
// status beat per batch (or per failed buffer) carrying the 32-byte header
// fields. Throughput is one byte per clock while the input is not stalled: each
// byte passes through an input register, one pass of header capture and
// byte-wide CRC-32 logic, and a result register with a one-entry skid; a result
// goes into the result register, or into the skid while that register is stalled.
// The record-capacity product is built over header bytes 20..23 and compared at
// byte 28, so no wide multiply sits in the byte path. The input stalls only while
// both the result register and the skid hold undelivered results. Write
// magic_word only while the block is idle.
module record_batch_frame_checker #(
   parameter int unsigned RECORD_HEADER_SIZE = rbfc_pkg::RBFC_RECORD_HEADER_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_first_offset,
   output logic [63:0] rsp_rec_total,
   output logic [63:0] rsp_batch_size,
   output logic [31:0] rsp_payload_crc,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_end_ff;
   logic [31:0]               magic_ff;
   logic                      hold;
   logic                      fire;
   logic                      req_accept;
   rbfc_pkg::rbfc_push_type   push;
   rbfc_pkg::rbfc_result_type result;

   assign req_stall   = in_valid_ff && hold;
   assign req_accept  = req_valid && !req_stall;
   assign fire        = in_valid_ff && !hold;
   assign in_valid_in = req_accept || (in_valid_ff && hold);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         magic_ff    <= 32'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            magic_ff <= csr_write_data;
         end
      end
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_buffer_end;
      end
   end

   rbfc_parser #(
      .RECORD_HEADER_SIZE(RECORD_HEADER_SIZE)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .buffer_end(in_end_ff),
      .magic_word(magic_ff),
      .push      (push)
   );

   rbfc_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_result(result)
   );

   assign rsp_status       = result.status;
   assign rsp_first_offset = result.first_offset;
   assign rsp_rec_total    = result.rec_total;
   assign rsp_batch_size   = result.batch_size;
   assign rsp_payload_crc  = result.payload_crc;

   // Input stalls only behind a waiting result.
   `RBFC_ASSERT_NOW(a_stall_has_result, clock, reset, req_stall, rsp_valid)
   // A short header never reports header fields.
   `RBFC_ASSERT_NOW(a_short_header_zero, clock, reset,
      rsp_valid && (rsp_status == rbfc_pkg::ST_HEADER_SHORT),
      (rsp_first_offset == 64'd0) && (rsp_rec_total == 64'd0) &&
      (rsp_batch_size == 64'd0) && (rsp_payload_crc == 32'd0))
   // A passing batch is at least a full header.
   `RBFC_ASSERT_NOW(a_ok_size, clock, reset,
      rsp_valid && (rsp_status == rbfc_pkg::ST_OK),
      rsp_batch_size >= rbfc_pkg::BATCH_HEADER_BYTES)
   // A new result needs a processed byte.
   `RBFC_ASSERT_NEXT(a_result_from_byte, clock, reset, !fire, !push.valid || fire)

endmodule
